// ----- sv/sliding_window_median_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the median filter
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWMF_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);
`define SWMF_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);
`define SWMF_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define SWMF_ASSERT_IMP(lbl, ant, cons, msg)
`define SWMF_ASSERT_NXT(lbl, ant, cons, msg)
`define SWMF_ASSERT_ALW(lbl, expr, msg)
`endif

`endif

// ----- sv/swmf_pkg.sv -----
// ----------------------------------------------------------------------------
// swmf_pkg
// Sizes, register codes and shared types of the median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int WS_BITS = 3;
  localparam int W_BITS  = 11;
  localparam int H_BITS  = 14;

  localparam int MAX_HALF    = (MAX_WINDOW - 1) / 2;
  localparam int HALF_BITS   = $clog2(MAX_HALF + 1);
  localparam int SIDE_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int RM_BITS     = $clog2(MAX_WINDOW);
  localparam int ROWSUM_BITS = $clog2(3 * MAX_WINDOW);
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int CX_BITS     = ((W_BITS > COL_BITS) ? W_BITS : COL_BITS) + 1;
  localparam int RX_BITS     = H_BITS + 1;
  localparam int COUNT_BITS  = H_BITS + W_BITS;

  localparam int WIN_LEN   = MAX_WINDOW * MAX_WINDOW;
  localparam int SLOT_BITS = $clog2(WIN_LEN);
  localparam int CNT_BITS  = $clog2(WIN_LEN + 1);

  localparam int MED_GROUP  = 8;
  localparam int MED_GROUPS = (WIN_LEN + MED_GROUP - 1) / MED_GROUP;
  localparam int PART_BITS  = $clog2(MED_GROUP + 1);

  localparam int LINE_DEPTH = MAX_WINDOW * (2 ** COL_BITS);
  localparam int ADDR_BITS  = RM_BITS + COL_BITS;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = H_BITS;

  localparam logic [WS_BITS-1:0] RST_WINDOW_SIZE  = WS_BITS'(3);
  localparam logic [W_BITS-1:0]  RST_IMAGE_WIDTH  = W_BITS'(640);
  localparam logic [H_BITS-1:0]  RST_IMAGE_HEIGHT = H_BITS'(480);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  load;
    logic [SLOT_BITS-1:0]  slot;
    logic [PIXEL_BITS-1:0] data;
    logic                  go;
    logic [CNT_BITS-1:0]   len;
  } med_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic [PIXEL_BITS-1:0] value;
  } med_stat_t;

endpackage

// ----- sv/swmf_if.sv -----
// ----------------------------------------------------------------------------
// swmf channel interfaces
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
interface swmf_in_if;
  import swmf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [PIXEL_BITS-1:0] pixel_in;
  modport source (output valid, output func, output pixel_in, input ready);
  modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface swmf_out_if;
  import swmf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last;
  modport source (output valid, output pixel_out, output last, input ready);
  modport sink   (input valid, input pixel_out, input last, output ready);
endinterface

interface swmf_cfg_if;
  import swmf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/sliding_window_median_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Raster-order square-window median filter with line stores and border bypass.
//
//   channel  dir  handshake     payload
//   feed     in   valid/ready   func, pixel_in
//   result   out  valid/ready   pixel_out, last
//   cfg      in   valid/ready   index, data
//
// An item that gives no result goes straight back to idle; a border pixel
// is copied from the line store. An interior pixel reads one window pixel
// per cycle through the single line-store read port, then the shared
// counting unit resolves the median one pixel bit at a time, top bit first.
// The result register lets the next item in while a result waits.
// Reset is synchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_defines.svh"

module sliding_window_median_filter (
  input  logic            clk,
  input  logic            rst,
  swmf_in_if.sink         feed,
  swmf_out_if.source      result,
  swmf_cfg_if.sink        cfg
);
  import swmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_BWAIT, S_LOAD, S_LWAIT, S_MED, S_OUT
  } state_t;

  state_t                state;
  logic [WS_BITS-1:0]    window_size;
  logic [W_BITS-1:0]     image_width;
  logic [H_BITS-1:0]     image_height;

  logic [H_BITS-1:0]     in_row;
  logic [COL_BITS-1:0]   in_col;
  logic [RM_BITS-1:0]    in_m7;
  logic [COUNT_BITS-1:0] in_count;
  logic [H_BITS-1:0]     out_row;
  logic [COL_BITS-1:0]   out_col;
  logic [RM_BITS-1:0]    out_m7;

  logic [RM_BITS-1:0]    li;
  logic [RM_BITS-1:0]    lj;
  logic [SLOT_BITS-1:0]  slot;
  logic                  ld_q;
  logic [SLOT_BITS-1:0]  ld_slot_q;

  logic [PIXEL_BITS-1:0] res_pix;
  logic                  out_valid;
  logic [PIXEL_BITS-1:0] out_pix;
  logic                  out_last;

  logic [HALF_BITS-1:0]   half;
  logic [W_BITS-1:0]      eff_w;
  logic [H_BITS-1:0]      eff_h;
  logic [SIDE_BITS-1:0]   side;
  logic [CNT_BITS-1:0]    len;
  logic [COUNT_BITS-1:0]  delay;
  logic                   border;
  logic                   cur_last;
  logic                   in_col_last;
  logic                   accept;
  logic                   img_done;
  logic                   ram_we;
  logic                   emit_go;
  logic                   cfg_wr;
  logic                   cfg_hit;
  logic                   out_load;
  logic [ROWSUM_BITS-1:0] row_sum;
  logic [RM_BITS-1:0]     win_row;
  logic [CX_BITS-1:0]     col_sum;
  logic                   ram_re;
  logic [ADDR_BITS-1:0]   ram_raddr;
  logic [PIXEL_BITS-1:0]  ram_rdata;
  med_ctrl_t              mctrl;
  med_stat_t              mstat;

  always_comb begin
    if (int'(window_size >> 1) > MAX_HALF) begin
      half = HALF_BITS'(MAX_HALF);
    end else begin
      half = HALF_BITS'(window_size >> 1);
    end
    if (image_width == '0) begin
      eff_w = W_BITS'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = W_BITS'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height == '0) ? H_BITS'(1) : image_height;
  end

  assign side  = SIDE_BITS'({half, 1'b1});
  assign len   = CNT_BITS'(side) * CNT_BITS'(side);
  assign delay = COUNT_BITS'(half) * COUNT_BITS'(eff_w) + COUNT_BITS'(half);

  assign border = (out_row < H_BITS'(half)) ||
                  (RX_BITS'(out_row) + RX_BITS'(half) >= RX_BITS'(eff_h)) ||
                  (CX_BITS'(out_col) < CX_BITS'(half)) ||
                  (CX_BITS'(out_col) + CX_BITS'(half) >= CX_BITS'(eff_w));
  assign cur_last = (out_row == eff_h - H_BITS'(1)) &&
                    (CX_BITS'(out_col) == CX_BITS'(eff_w) - CX_BITS'(1));
  assign in_col_last = (CX_BITS'(in_col) == CX_BITS'(eff_w) - CX_BITS'(1));

  assign accept   = feed.valid && feed.ready;
  assign img_done = (in_row >= eff_h);
  assign ram_we   = accept && !img_done && !feed.func;
  assign emit_go  = img_done || (!feed.func && (in_count >= delay));
  assign cfg_wr   = cfg.valid && cfg.ready;
  assign cfg_hit  = (cfg.index == REG_WINDOW_SIZE) || (cfg.index == REG_IMAGE_WIDTH) ||
                    (cfg.index == REG_IMAGE_HEIGHT);
  assign out_load = (state == S_OUT) && (!out_valid || result.ready);

  always_comb begin
    row_sum = ROWSUM_BITS'(out_m7) + ROWSUM_BITS'(li) + ROWSUM_BITS'(MAX_WINDOW) -
              ROWSUM_BITS'(half);
    if (row_sum >= ROWSUM_BITS'(2 * MAX_WINDOW)) begin
      row_sum = row_sum - ROWSUM_BITS'(2 * MAX_WINDOW);
    end else if (row_sum >= ROWSUM_BITS'(MAX_WINDOW)) begin
      row_sum = row_sum - ROWSUM_BITS'(MAX_WINDOW);
    end
    win_row = row_sum[RM_BITS-1:0];
    col_sum = CX_BITS'(out_col) + CX_BITS'(lj) - CX_BITS'(half);
  end

  assign ram_re    = ((state == S_START) && border) || (state == S_LOAD);
  assign ram_raddr = (state == S_LOAD) ? {win_row, col_sum[COL_BITS-1:0]} : {out_m7, out_col};

  swmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_m7, in_col}),
    .wdata (feed.pixel_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mctrl.load = ld_q;
  assign mctrl.slot = ld_slot_q;
  assign mctrl.data = ram_rdata;
  assign mctrl.go   = (state == S_LWAIT);
  assign mctrl.len  = len;

  swmf_median u_median (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctrl),
    .stat (mstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_size  <= RST_WINDOW_SIZE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      in_row       <= '0;
      in_col       <= '0;
      in_m7        <= '0;
      in_count     <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_m7       <= '0;
      ld_q         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      ld_q      <= (state == S_LOAD);
      ld_slot_q <= slot;
      if (result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (ram_we) begin
              in_count <= in_count + COUNT_BITS'(1);
              if (in_col_last) begin
                in_col <= '0;
                in_row <= in_row + H_BITS'(1);
                in_m7  <= (in_m7 == RM_BITS'(MAX_WINDOW - 1)) ? '0 : in_m7 + RM_BITS'(1);
              end else begin
                in_col <= in_col + COL_BITS'(1);
              end
            end
            if (emit_go) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          li   <= '0;
          lj   <= '0;
          slot <= '0;
          state <= border ? S_BWAIT : S_LOAD;
        end
        S_BWAIT: begin
          res_pix <= ram_rdata;
          state   <= S_OUT;
        end
        S_LOAD: begin
          slot <= slot + SLOT_BITS'(1);
          if (SIDE_BITS'(lj) == side - SIDE_BITS'(1)) begin
            lj <= '0;
            if (SIDE_BITS'(li) == side - SIDE_BITS'(1)) begin
              state <= S_LWAIT;
            end else begin
              li <= li + RM_BITS'(1);
            end
          end else begin
            lj <= lj + RM_BITS'(1);
          end
        end
        S_LWAIT: begin
          state <= S_MED;
        end
        S_MED: begin
          if (mstat.done) begin
            res_pix <= mstat.value;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_pix   <= res_pix;
            out_last  <= cur_last;
            state     <= S_IDLE;
            if (cur_last) begin
              in_row   <= '0;
              in_col   <= '0;
              in_m7    <= '0;
              in_count <= '0;
              out_row  <= '0;
              out_col  <= '0;
              out_m7   <= '0;
            end else if (CX_BITS'(out_col) == CX_BITS'(eff_w) - CX_BITS'(1)) begin
              out_col <= '0;
              out_row <= out_row + H_BITS'(1);
              out_m7  <= (out_m7 == RM_BITS'(MAX_WINDOW - 1)) ? '0 : out_m7 + RM_BITS'(1);
            end else begin
              out_col <= out_col + COL_BITS'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr && cfg_hit) begin
        case (cfg_reg_t'(cfg.index))
          REG_WINDOW_SIZE:  window_size  <= cfg.data[WS_BITS-1:0];
          REG_IMAGE_WIDTH:  image_width  <= cfg.data[W_BITS-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg.data[H_BITS-1:0];
          default: ;
        endcase
        in_row   <= '0;
        in_col   <= '0;
        in_m7    <= '0;
        in_count <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_m7   <= '0;
      end
    end
  end

  assign feed.ready       = (state == S_IDLE);
  assign cfg.ready        = (state == S_IDLE) && !feed.valid;
  assign result.valid     = out_valid;
  assign result.pixel_out = out_pix;
  assign result.last      = out_last;

  `SWMF_ASSERT_IMP(a_port_excl, ram_we, !ram_re, "line store read and write collide")
  `SWMF_ASSERT_NXT(a_last_restart, out_load && cur_last,
                   in_row == '0 && out_row == '0 && in_count == '0,
                   "counters not cleared after last item")
  `SWMF_ASSERT_ALW(a_out_behind, out_row <= in_row, "output row ahead of input row")

endmodule

// ----- sv/swmf_ram.sv -----
// ----------------------------------------------------------------------------
// swmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/swmf_median.sv -----
// ----------------------------------------------------------------------------
// swmf_median
// Window registers and a bit-serial radix select that finds the median.
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_defines.svh"

module swmf_median (
  input  logic                clk,
  input  logic                rst,
  input  swmf_pkg::med_ctrl_t ctrl,
  output swmf_pkg::med_stat_t stat
);
  import swmf_pkg::*;

  localparam logic [PIXEL_BITS-1:0] TOP_BIT = PIXEL_BITS'(1) << (PIXEL_BITS - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_COUNT, PH_DECIDE} phase_t;

  phase_t                phase;
  logic [PIXEL_BITS-1:0] window_regs [WIN_LEN];
  logic [PIXEL_BITS-1:0] prefix;
  logic [PIXEL_BITS-1:0] hi_mask;
  logic [PIXEL_BITS-1:0] bsel;
  logic [CNT_BITS-1:0]   rank;
  logic [CNT_BITS-1:0]   len_q;
  logic [PART_BITS-1:0]  part [MED_GROUPS];
  logic [PART_BITS-1:0]  part_next [MED_GROUPS];
  logic [CNT_BITS-1:0]   cnt0;
  logic                  done;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      window_regs[ctrl.slot] <= ctrl.data;
    end
  end

  always_comb begin
    int e;
    for (int g = 0; g < MED_GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < MED_GROUP; k++) begin
        e = g * MED_GROUP + k;
        if (e < WIN_LEN) begin
          if ((CNT_BITS'(e) < len_q) &&
              (((window_regs[e] ^ prefix) & hi_mask) == '0) &&
              ((window_regs[e] & bsel) == '0)) begin
            part_next[g] = part_next[g] + PART_BITS'(1);
          end
        end
      end
    end
  end

  always_comb begin
    cnt0 = '0;
    for (int g = 0; g < MED_GROUPS; g++) begin
      cnt0 = cnt0 + CNT_BITS'(part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (ctrl.go) begin
            len_q   <= ctrl.len;
            rank    <= ctrl.len >> 1;
            prefix  <= '0;
            hi_mask <= '0;
            bsel    <= TOP_BIT;
            phase   <= PH_COUNT;
          end
        end
        PH_COUNT: begin
          part  <= part_next;
          phase <= PH_DECIDE;
        end
        PH_DECIDE: begin
          if (rank >= cnt0) begin
            prefix <= prefix | bsel;
            rank   <= rank - cnt0;
          end
          hi_mask <= (hi_mask >> 1) | TOP_BIT;
          bsel    <= bsel >> 1;
          if (bsel[0]) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else begin
            phase <= PH_COUNT;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign stat.done  = done;
  assign stat.value = prefix;

  `SWMF_ASSERT_IMP(a_go_idle, ctrl.go, phase == PH_IDLE, "median start while busy")
  `SWMF_ASSERT_IMP(a_load_idle, ctrl.load, phase == PH_IDLE, "window load while busy")
  `SWMF_ASSERT_IMP(a_rank_range, phase != PH_IDLE, rank < len_q, "rank out of window")

endmodule
